/* hdl/prqa_pkg.sv */
// Shared types and codes for the priority ready queue with aging.
// No dependencies; used by the top level by scoped names.
package prqa_pkg;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] status_t;

  localparam cmd_t CMD_ENQ = 2'd0;
  localparam cmd_t CMD_DEQ = 2'd1;
  localparam cmd_t CMD_SETP = 2'd2;
  localparam cmd_t CMD_REG = 2'd3;

  localparam status_t ST_OK = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_REJECT = 2'd2;

  localparam logic [1:0] REG_THRESH = 2'd0;
  localparam logic [1:0] REG_INTERVAL = 2'd1;
  localparam logic [1:0] REG_DFLT_PRIO = 2'd2;

  localparam int AddrW = 4;

  localparam logic [31:0] THRESH_RESET = 32'd100;
  localparam logic [15:0] INTERVAL_RESET = 16'd100;
  localparam logic [4:0] PRIO_RESET = 5'd1;

endpackage

/* hdl/priority_ready_queue_with_aging.sv */
// Top level of the priority ready queue with aging: sequencer, level lists, APB registers.
// Depends on prqa_pkg and prqa_ram (task link, priority and stamp memories).
//
// One command per transaction, issued with start while busy is low; exactly one result
// follows on out_valid for a single cycle and cannot be stalled. A set priority to a level
// out of range, or a non-dequeue command with a task ID out of range, is rejected at once:
// its result is registered and follows in the next cycle, and busy never rises. Dequeue
// runs the aging pass when due before it picks a task: that pass walks every task on
// levels 1 and up through the shared task memories. No memory clearing pass is needed
// after reset.
module priority_ready_queue_with_aging #(
  parameter int PRIORITY_LEVELS = 4,
  parameter int MAX_TASKS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_cmd,
  input  logic [5:0]                    in_task_id,
  input  logic [4:0]                    in_new_priority,
  input  logic [31:0]                   in_now_ms,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [5:0]                    out_task_id,
  output logic [4:0]                    out_priority,
  output logic [6:0]                    out_ready_total,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prqa_pkg::AddrW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int TW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int LW = $clog2(PRIORITY_LEVELS);
  localparam int L = PRIORITY_LEVELS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ENQ = 4'd1;
  localparam logic [3:0] S_SETP = 4'd2;
  localparam logic [3:0] S_SPUSH = 4'd3;
  localparam logic [3:0] S_AG_LVL = 4'd4;
  localparam logic [3:0] S_AG_RD = 4'd5;
  localparam logic [3:0] S_AG_EV = 4'd6;
  localparam logic [3:0] S_AG_PUSH = 4'd7;
  localparam logic [3:0] S_PICK = 4'd8;
  localparam logic [3:0] S_DEQ = 4'd9;

  // configuration
  logic [31:0] thr_r;
  logic [15:0] interval_r;
  logic [4:0]  dflt_r;
  logic        cfg_wr;

  // control and level lists
  logic [3:0]    state_r, state_nxt;
  logic [TW-1:0] head_r [L];
  logic [TW-1:0] tail_r [L];
  logic [CW-1:0] cnt_r [L];
  logic [L-1:0]  bitmap_r;
  logic [MAX_TASKS-1:0] queued_r, pvld_r, svld_r;
  logic [15:0]   deq_cnt_r;
  logic [CW-1:0] total_r;

  // transaction capture
  logic [1:0]    cmd_r;
  logic [TW-1:0] id_r;
  logic [4:0]    np_r;
  logic [31:0]   now_r;

  // walk state
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic [TW-1:0] walk_r, walk_nxt, cur_r, cur_nxt;
  logic [CW-1:0] n_r, n_nxt, i_r, i_nxt;

  // outputs
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [5:0]    out_tid_r;
  logic [4:0]    out_pri_r;

  logic          accept;
  logic [15:0]   deq_inc;
  logic          aging_due;
  logic [LW-1:0] pick_lvl;
  logic [LW-1:0] li;
  logic [TW-1:0] lv_head, lv_tail, head_nxt, tail_nxt;
  logic [CW-1:0] lv_cnt, cnt_nxt;
  logic          lv_we;

  logic          ul_en, ps_en;
  logic [TW-1:0] ut, pt;
  logic [TW-1:0] rd_addr;
  logic [TW-1:0] nx_rd, pv_rd;
  logic [4:0]    prio_rd;
  logic [31:0]   stamp_rd;
  logic          nx_we, pv_we;
  logic [TW-1:0] nx_wa, nx_wd, pv_wa, pv_wd;
  logic          pr_we, st_we;
  logic [TW-1:0] pr_wa, st_wa;
  logic [4:0]    pr_wd;
  logic [31:0]   st_wd;

  logic [4:0]    prio_cur, enq_prio;
  logic [31:0]   stamp_cur;
  logic          age_hit;
  logic          q_set, q_clr, tot_inc, tot_dec;
  logic          resp;
  logic [1:0]    resp_st;
  logic [5:0]    resp_tid;
  logic [4:0]    resp_pri;

  assign accept = start && !busy;
  assign busy = (state_r != S_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      prqa_pkg::REG_THRESH:    prdata = thr_r;
      prqa_pkg::REG_INTERVAL:  prdata = 32'(interval_r);
      prqa_pkg::REG_DFLT_PRIO: prdata = 32'(dflt_r);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= prqa_pkg::THRESH_RESET;
      interval_r <= prqa_pkg::INTERVAL_RESET;
      dflt_r <= prqa_pkg::PRIO_RESET;
    end else if (cfg_wr) begin
      if (paddr[3:2] == prqa_pkg::REG_THRESH) begin
        thr_r <= pwdata;
      end
      if (paddr[3:2] == prqa_pkg::REG_INTERVAL) begin
        interval_r <= pwdata[15:0];
      end
      if (paddr[3:2] == prqa_pkg::REG_DFLT_PRIO) begin
        dflt_r <= pwdata[4:0];
      end
    end
  end

  // task memories
  prqa_ram #(.WIDTH(TW), .DEPTH(MAX_TASKS)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(rd_addr), .rdata(nx_rd)
  );
  prqa_ram #(.WIDTH(TW), .DEPTH(MAX_TASKS)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(rd_addr), .rdata(pv_rd)
  );
  prqa_ram #(.WIDTH(5), .DEPTH(MAX_TASKS)) u_prio (
    .clk(clk), .we(pr_we), .waddr(pr_wa), .wdata(pr_wd), .raddr(rd_addr), .rdata(prio_rd)
  );
  prqa_ram #(.WIDTH(32), .DEPTH(MAX_TASKS)) u_stamp (
    .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(rd_addr), .rdata(stamp_rd)
  );

  assign deq_inc = deq_cnt_r + 16'd1;
  assign aging_due = (deq_inc >= interval_r);
  assign prio_cur = pvld_r[id_r] ? prio_rd : prqa_pkg::PRIO_RESET;
  assign enq_prio = (cmd_r == prqa_pkg::CMD_REG) ? dflt_r : prio_cur;
  assign stamp_cur = svld_r[walk_r] ? stamp_rd : 32'd0;
  assign age_hit = (stamp_cur != 32'd0) && ((now_r - stamp_cur) >= thr_r);

  always_comb begin
    pick_lvl = '0;
    for (int k = L - 1; k >= 0; k--) begin
      if (bitmap_r[k]) begin
        pick_lvl = LW'(k);
      end
    end
  end

  always_comb begin
    unique case (state_r)
      S_ENQ:     li = LW'(enq_prio);
      S_SETP:    li = LW'(prio_cur);
      S_SPUSH:   li = LW'(np_r);
      S_AG_LVL:  li = lvl_r;
      S_AG_EV:   li = lvl_r;
      S_AG_PUSH: li = lvl_r - LW'(1);
      S_PICK:    li = pick_lvl;
      S_DEQ:     li = lvl_r;
      default:   li = '0;
    endcase
  end

  // list surgery on level li: push to tail or unlink a task
  always_comb begin
    lv_head = head_r[li];
    lv_tail = tail_r[li];
    lv_cnt = cnt_r[li];
    head_nxt = lv_head;
    tail_nxt = lv_tail;
    cnt_nxt = lv_cnt;
    lv_we = 1'b0;
    nx_we = 1'b0;
    nx_wa = lv_tail;
    nx_wd = pt;
    pv_we = 1'b0;
    pv_wa = pt;
    pv_wd = lv_tail;
    if (ps_en) begin
      lv_we = 1'b1;
      if (lv_cnt == '0) begin
        head_nxt = pt;
      end else begin
        nx_we = 1'b1;
        pv_we = 1'b1;
      end
      tail_nxt = pt;
      cnt_nxt = lv_cnt + CW'(1);
    end else if (ul_en && lv_cnt != '0) begin
      lv_we = 1'b1;
      if (lv_head == ut) begin
        head_nxt = nx_rd;
      end else begin
        nx_we = 1'b1;
        nx_wa = pv_rd;
        nx_wd = nx_rd;
      end
      if (lv_tail == ut) begin
        tail_nxt = pv_rd;
      end else begin
        pv_we = 1'b1;
        pv_wa = nx_rd;
        pv_wd = pv_rd;
      end
      cnt_nxt = lv_cnt - CW'(1);
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    lvl_nxt = lvl_r;
    walk_nxt = walk_r;
    cur_nxt = cur_r;
    n_nxt = n_r;
    i_nxt = i_r;
    rd_addr = walk_r;
    ul_en = 1'b0;
    ut = id_r;
    ps_en = 1'b0;
    pt = id_r;
    pr_we = 1'b0;
    pr_wa = id_r;
    pr_wd = enq_prio;
    st_we = 1'b0;
    st_wa = id_r;
    st_wd = now_r;
    q_set = 1'b0;
    q_clr = 1'b0;
    tot_inc = 1'b0;
    tot_dec = 1'b0;
    resp = 1'b0;
    resp_st = prqa_pkg::ST_OK;
    resp_tid = '0;
    resp_pri = '0;
    unique case (state_r)
      S_IDLE: begin
        rd_addr = TW'(in_task_id);
        if (accept) begin
          if (in_cmd == prqa_pkg::CMD_DEQ) begin
            lvl_nxt = LW'(L - 1);
            state_nxt = (aging_due && thr_r != 32'd0) ? S_AG_LVL : S_PICK;
          end else if (32'(in_task_id) >= 32'(MAX_TASKS)) begin
            resp = 1'b1;
            resp_st = prqa_pkg::ST_REJECT;
          end else if (in_cmd == prqa_pkg::CMD_SETP) begin
            if (32'(in_new_priority) >= 32'(L)) begin
              resp = 1'b1;
              resp_st = prqa_pkg::ST_REJECT;
            end else begin
              state_nxt = S_SETP;
            end
          end else begin
            state_nxt = S_ENQ;
          end
        end
      end
      S_ENQ: begin
        resp = 1'b1;
        state_nxt = S_IDLE;
        if (queued_r[id_r] || 32'(enq_prio) >= 32'(L)) begin
          resp_st = prqa_pkg::ST_REJECT;
        end else begin
          pr_we = 1'b1;
          st_we = 1'b1;
          q_set = 1'b1;
          ps_en = 1'b1;
          tot_inc = 1'b1;
        end
      end
      S_SETP: begin
        if (prio_cur == np_r) begin
          resp = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          pr_we = 1'b1;
          pr_wd = np_r;
          if (queued_r[id_r]) begin
            ul_en = 1'b1;
            state_nxt = S_SPUSH;
          end else begin
            resp = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_SPUSH: begin
        ps_en = 1'b1;
        resp = 1'b1;
        state_nxt = S_IDLE;
      end
      S_AG_LVL: begin
        if (lvl_r == '0) begin
          state_nxt = S_PICK;
        end else if (lv_cnt == '0) begin
          lvl_nxt = lvl_r - LW'(1);
        end else begin
          n_nxt = lv_cnt;
          walk_nxt = lv_head;
          i_nxt = '0;
          state_nxt = S_AG_RD;
        end
      end
      S_AG_RD: begin
        state_nxt = S_AG_EV;
      end
      S_AG_EV, S_AG_PUSH: begin
        if (state_r == S_AG_EV) begin
          cur_nxt = walk_r;
          walk_nxt = nx_rd;
        end else begin
          ps_en = 1'b1;
          pt = cur_r;
        end
        if (state_r == S_AG_EV && age_hit) begin
          ul_en = 1'b1;
          ut = walk_r;
          pr_we = 1'b1;
          pr_wa = walk_r;
          pr_wd = 5'(lvl_r - LW'(1));
          st_we = 1'b1;
          st_wa = walk_r;
          state_nxt = S_AG_PUSH;
        end else if ((i_r + CW'(1)) == n_r) begin
          lvl_nxt = lvl_r - LW'(1);
          state_nxt = S_AG_LVL;
        end else begin
          i_nxt = i_r + CW'(1);
          state_nxt = S_AG_RD;
        end
      end
      S_PICK: begin
        rd_addr = lv_head;
        cur_nxt = lv_head;
        lvl_nxt = pick_lvl;
        if (bitmap_r == '0) begin
          resp = 1'b1;
          resp_st = prqa_pkg::ST_EMPTY;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DEQ;
        end
      end
      S_DEQ: begin
        ul_en = 1'b1;
        ut = cur_r;
        q_clr = 1'b1;
        tot_dec = (total_r != '0);
        resp = 1'b1;
        resp_tid = 6'(cur_r);
        resp_pri = 5'(lvl_r);
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bitmap_r <= '0;
      queued_r <= '0;
      pvld_r <= '0;
      svld_r <= '0;
      deq_cnt_r <= '0;
      total_r <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < L; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      out_valid_r <= resp;
      if (lv_we) begin
        cnt_r[li] <= cnt_nxt;
        bitmap_r[li] <= (cnt_nxt != '0);
      end
      if (pr_we) begin
        pvld_r[pr_wa] <= 1'b1;
      end
      if (st_we) begin
        svld_r[st_wa] <= 1'b1;
      end
      if (q_set) begin
        queued_r[id_r] <= 1'b1;
      end
      if (q_clr) begin
        queued_r[cur_r] <= 1'b0;
      end
      if (tot_inc) begin
        total_r <= total_r + CW'(1);
      end else if (tot_dec) begin
        total_r <= total_r - CW'(1);
      end
      if (accept && in_cmd == prqa_pkg::CMD_DEQ) begin
        deq_cnt_r <= aging_due ? 16'd0 : deq_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lv_we) begin
      head_r[li] <= head_nxt;
      tail_r[li] <= tail_nxt;
    end
    if (accept) begin
      cmd_r <= in_cmd;
      id_r <= TW'(in_task_id);
      np_r <= in_new_priority;
      now_r <= in_now_ms;
    end
    lvl_r <= lvl_nxt;
    walk_r <= walk_nxt;
    cur_r <= cur_nxt;
    n_r <= n_nxt;
    i_r <= i_nxt;
    if (resp) begin
      out_status_r <= resp_st;
      out_tid_r <= resp_tid;
      out_pri_r <= resp_pri;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_task_id = out_tid_r;
  assign out_priority = out_pri_r;
  assign out_ready_total = 7'(total_r);

  a_resp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while sequencer busy");

  a_bitmap_total: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_AG_PUSH && state_r != S_SPUSH) |-> ((bitmap_r != '0) == (total_r != '0)))
    else $error("level bitmap disagrees with ready total");

  a_total_max: assert property (@(posedge clk) disable iff (!rst_n)
    32'(total_r) <= 32'(MAX_TASKS))
    else $error("ready total above task count");

  a_one_resp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid || $past(accept))
    else $error("result without transaction");

endmodule

/* hdl/prqa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prqa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
